FILE: rtl/egm_pkg.sv
// Shared types, constants and index helpers for the Mandel Green operator block.
// No dependencies; every other file except egm_div_pipe imports this package.
package egm_pkg;

  localparam int NUM_ROWS    = 6;
  localparam int Q_SHIFT     = 30;
  localparam int U_FRAC      = 31;
  localparam int G_FRAC      = 32;
  localparam int CFG_IDX_W   = 8;
  localparam int OUT_DATA_W  = 200;

  localparam logic [31:0] LAMBDA_RST = 32'd3780923;
  localparam logic [31:0] MU_RST     = 32'd2520615;
  localparam logic [30:0] SQRT2_Q30  = 31'd1518500250;
  localparam logic [31:0] POS_SAT    = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_SAT    = 32'h8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LAMBDA = 8'd0,
    REG_MU     = 8'd1
  } cfg_reg_t;

  localparam logic [1:0] PAIR_A [NUM_ROWS] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd0, 2'd0};
  localparam logic [1:0] PAIR_B [NUM_ROWS] = '{2'd0, 2'd1, 2'd2, 2'd2, 2'd2, 2'd1};

  typedef struct packed {
    logic [NUM_ROWS-1:0][31:0] u;
    logic [30:0]               cp;
    logic                      zero;
  } egm_item_t;

  // Mandel index of the symmetric pair (a,b).
  function automatic logic [2:0] sym_idx(input logic [1:0] a, input logic [1:0] b);
    logic [2:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (a == b) begin
      return {1'b0, a};
    end
    return 3'd6 - sum;
  endfunction

endpackage

FILE: rtl/egm_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on nothing; used by egm_front and egm_row.
module egm_div_pipe #(
  parameter int W = 32,
  parameter int F = 32
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] r0,
  input  logic [W-1:0] d,
  input  logic [F-1:0] low,
  output logic [F-1:0] q
);

  logic [W-1:0] rem_r [F];
  logic [W-1:0] d_r   [F];
  logic [F-1:0] low_r [F];
  logic [F-1:0] q_r   [F];

  for (genvar s = 0; s < F; s++) begin : g_stage
    logic [W-1:0] rin;
    logic [W-1:0] din;
    logic [F-1:0] lin;
    logic [F-1:0] qin;
    logic [W:0]   trial;
    logic         fits;
    logic [F-1:0] q_nxt;
    logic [W-1:0] rem_nxt;

    if (s == 0) begin : g_first
      assign rin = r0;
      assign din = d;
      assign lin = low;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem_r[s-1];
      assign din = d_r[s-1];
      assign lin = low_r[s-1];
      assign qin = q_r[s-1];
    end

    assign trial = {rin, lin[F-1-s]};
    assign fits  = trial >= {1'b0, din};

    always_comb begin
      q_nxt          = qin;
      q_nxt[F-1-s]   = fits;
      rem_nxt        = fits ? W'(trial - {1'b0, din}) : trial[W-1:0];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt;
        d_r[s]   <= din;
        low_r[s] <= lin;
        q_r[s]   <= q_nxt;
      end
    end
  end

  assign q = q_r[F-1];

endmodule

FILE: rtl/egm_front.sv
// Front pipeline: wave vector products, |k|^2, unit products u_ab and c'.
// Depends on egm_pkg and egm_div_pipe.
module egm_front import egm_pkg::*; #(
  parameter int K_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [K_WIDTH-1:0] kx,
  input  logic signed [K_WIDTH-1:0] ky,
  input  logic signed [K_WIDTH-1:0] kz,
  input  logic [31:0]               lambda,
  input  logic [31:0]               mu,
  output logic                      item_valid,
  output egm_item_t                 item,
  input  logic                      item_take
);

  localparam int PW = 2 * K_WIDTH;

  typedef struct packed {
    logic                zero;
    logic [NUM_ROWS-1:0] sgn;
    logic [NUM_ROWS-1:0] q0;
  } front_tag_t;

  logic                 fe;
  logic                 f1_v_r;
  logic signed [PW-1:0] p_r   [NUM_ROWS];
  logic signed [PW-1:0] p_nxt [NUM_ROWS];
  logic [PW-1:0]        k2_r;
  logic [PW-1:0]        k2_nxt;
  logic signed [K_WIDTH-1:0] ks [3];

  logic [PW-1:0]        mag   [NUM_ROWS];
  logic [PW-1:0]        r0    [NUM_ROWS];
  logic [U_FRAC-1:0]    uq    [NUM_ROWS];
  logic [U_FRAC-1:0]    cq;
  front_tag_t           tag_in;
  front_tag_t           tag_r [U_FRAC];
  logic [U_FRAC-1:0]    sv_r;
  logic [33:0]          cp_a;
  logic [33:0]          cp_b;
  logic [31:0]          cp_sum;

  assign fe       = !sv_r[U_FRAC-1] || item_take;
  assign in_ready = fe;

  always_comb begin
    ks[0] = kx;
    ks[1] = ky;
    ks[2] = kz;
    for (int n = 0; n < NUM_ROWS; n++) begin
      p_nxt[n] = PW'(ks[PAIR_A[n]]) * PW'(ks[PAIR_B[n]]);
    end
    k2_nxt = $unsigned(p_nxt[0]) + $unsigned(p_nxt[1]) + $unsigned(p_nxt[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else if (fe) begin
      f1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      p_r  <= p_nxt;
      k2_r <= k2_nxt;
    end
  end

  always_comb begin
    tag_in.zero = (k2_r == '0);
    for (int n = 0; n < NUM_ROWS; n++) begin
      mag[n]         = p_r[n][PW-1] ? PW'(-p_r[n]) : PW'(p_r[n]);
      tag_in.sgn[n]  = p_r[n][PW-1];
      tag_in.q0[n]   = (mag[n] == k2_r);
      r0[n]          = tag_in.q0[n] ? '0 : mag[n];
    end
    cp_a = 34'(lambda) + 34'(mu);
    cp_b = 34'(lambda) + {1'b0, mu, 1'b0};
  end

  for (genvar n = 0; n < NUM_ROWS; n++) begin : g_udiv
    egm_div_pipe #(.W(PW), .F(U_FRAC)) u_div (
      .clk (clk),
      .en  (fe),
      .r0  (r0[n]),
      .d   (k2_r),
      .low ('0),
      .q   (uq[n])
    );
  end

  egm_div_pipe #(.W(34), .F(U_FRAC)) u_cpdiv (
    .clk (clk),
    .en  (fe),
    .r0  (cp_a),
    .d   (cp_b),
    .low ('0),
    .q   (cq)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= '0;
    end else if (fe) begin
      sv_r <= {sv_r[U_FRAC-2:0], f1_v_r};
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      tag_r[0] <= tag_in;
      for (int s = 1; s < U_FRAC; s++) begin
        tag_r[s] <= tag_r[s-1];
      end
    end
  end

  always_comb begin
    logic [32:0] rnd;
    for (int n = 0; n < NUM_ROWS; n++) begin
      rnd = {1'b0, tag_r[U_FRAC-1].q0[n], uq[n]} + 33'd1;
      item.u[n] = tag_r[U_FRAC-1].sgn[n] ? 32'(-rnd[32:1]) : rnd[32:1];
    end
    cp_sum    = {1'b0, cq} + 32'd1;
    item.cp   = cp_sum[31:1];
    item.zero = tag_r[U_FRAC-1].zero;
  end

  assign item_valid = sv_r[U_FRAC-1];

endmodule

FILE: rtl/egm_row.sv
// Row sequencer and row pipeline: six entries per row, Q30 products, Mandel scale,
// division by mu and saturation. Depends on egm_pkg and egm_div_pipe.
module egm_row import egm_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      item_valid,
  input  egm_item_t                 item,
  output logic                      item_take,
  input  logic [31:0]               mu,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0]                out_row,
  output logic [NUM_ROWS-1:0][31:0] out_g,
  output logic                      out_last
);

  localparam logic [61:0] HALF62 = 62'd1 << (Q_SHIFT - 1);
  localparam logic [65:0] HALF66 = 66'd1 << (Q_SHIFT - 1);
  localparam logic [2:0]  LAST_ROW = 3'(NUM_ROWS - 1);

  typedef struct packed {
    logic [2:0] row;
    logic       last;
    logic       zero;
  } row_tag_t;

  typedef struct packed {
    row_tag_t            rt;
    logic [NUM_ROWS-1:0] sat;
    logic [NUM_ROWS-1:0] neg;
  } div_tag_t;

  logic       re;
  logic       issue;
  logic       can_load;
  logic       x_v_r;
  egm_item_t  x_item_r;
  logic [2:0] row_r;

  logic v1_r, v2_r, v3_r, v4_r;
  row_tag_t t1_r, t2_r, t3_r, t4_r;
  logic [30:0] cp1_r;

  logic signed [34:0] s1_r  [NUM_ROWS];
  logic signed [34:0] s1_nxt[NUM_ROWS];
  logic [61:0]        pm1_r [NUM_ROWS];
  logic [61:0]        pm1_nxt [NUM_ROWS];
  logic [NUM_ROWS-1:0] ps1_r, ps1_nxt;

  logic signed [34:0] s2_r  [NUM_ROWS];
  logic [61:0]        c2_r  [NUM_ROWS];
  logic [61:0]        c2_nxt[NUM_ROWS];
  logic [NUM_ROWS-1:0] ps2_r;

  logic [34:0]        vm3_r [NUM_ROWS];
  logic [34:0]        vm3_nxt [NUM_ROWS];
  logic [65:0]        pv3_r [NUM_ROWS];
  logic [NUM_ROWS-1:0] vn3_r, vn3_nxt;

  logic [31:0]        r04_r [NUM_ROWS];
  logic [31:0]        r04_nxt [NUM_ROWS];
  logic [31:0]        low4_r [NUM_ROWS];
  logic [31:0]        low4_nxt [NUM_ROWS];
  logic [NUM_ROWS-1:0] sat4_r, sat4_nxt, vn4_r;

  logic [G_FRAC-1:0]  dq [NUM_ROWS];
  logic [G_FRAC-1:0]  dv_r;
  div_tag_t           dt_in;
  div_tag_t           dt_r [G_FRAC];

  logic [NUM_ROWS-1:0][31:0] g_nxt;

  logic [1:0]  mi, mj, nl, nm;
  logic [31:0] um, un;
  logic [30:0] ma, mb;
  logic signed [34:0] acc;
  logic [62:0] r2sum;
  logic [62:0] r3sum;
  logic [66:0] r4sum;
  logic signed [35:0] ts, v;
  logic [1:0]  sh;
  logic [35:0] mg;
  logic [44:0] nn;
  logic [31:0] hi;

  function automatic logic [30:0] mag31(input logic [31:0] a);
    return a[31] ? 31'(-a) : a[30:0];
  endfunction

  assign re        = !out_valid || out_ready;
  assign issue     = x_v_r && re;
  assign can_load  = !x_v_r || (issue && row_r == LAST_ROW);
  assign item_take = can_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_v_r <= 1'b0;
      row_r <= '0;
    end else if (can_load) begin
      x_v_r <= item_valid;
      row_r <= '0;
    end else if (issue) begin
      row_r <= row_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && item_valid) begin
      x_item_r <= item;
    end
  end

  // R1: delta sums and u_ij * u_lm
  always_comb begin
    mi = PAIR_A[row_r];
    mj = PAIR_B[row_r];
    um = x_item_r.u[row_r];
    ma = mag31(um);
    for (int n = 0; n < NUM_ROWS; n++) begin
      nl  = PAIR_A[n];
      nm  = PAIR_B[n];
      acc = '0;
      if (mi == nl) acc = acc + 35'(signed'(x_item_r.u[sym_idx(mj, nm)]));
      if (mi == nm) acc = acc + 35'(signed'(x_item_r.u[sym_idx(mj, nl)]));
      if (mj == nl) acc = acc + 35'(signed'(x_item_r.u[sym_idx(mi, nm)]));
      if (mj == nm) acc = acc + 35'(signed'(x_item_r.u[sym_idx(mi, nl)]));
      s1_nxt[n]  = acc;
      un         = x_item_r.u[n];
      mb         = mag31(un);
      pm1_nxt[n] = 62'(ma) * 62'(mb);
      ps1_nxt[n] = um[31] ^ un[31];
    end
  end

  // R2: round, times c'
  always_comb begin
    for (int n = 0; n < NUM_ROWS; n++) begin
      r2sum     = 63'(pm1_r[n]) + 63'(HALF62);
      c2_nxt[n] = 62'(cp1_r) * 62'(r2sum[60:30]);
    end
  end

  // R3: round, v = s - 4t, sqrt2 product
  always_comb begin
    for (int n = 0; n < NUM_ROWS; n++) begin
      r3sum      = 63'(c2_r[n]) + 63'(HALF62);
      ts         = ps2_r[n] ? -36'(r3sum[60:30]) : 36'(r3sum[60:30]);
      v          = 36'(s2_r[n]) - (ts <<< 2);
      vn3_nxt[n] = v[35];
      vm3_nxt[n] = v[35] ? 35'(-v) : v[34:0];
    end
  end

  // R4: Mandel scale, dividend and overflow check
  always_comb begin
    for (int n = 0; n < NUM_ROWS; n++) begin
      sh = 2'(t3_r.row >= 3'd3) + 2'(n >= 3);
      r4sum = 67'(pv3_r[n]) + 67'(HALF66);
      case (sh)
        2'd1:    mg = r4sum[65:30];
        2'd2:    mg = {vm3_r[n], 1'b0};
        default: mg = {1'b0, vm3_r[n]};
      endcase
      nn           = 45'({mg, 8'd0}) + 45'(mu[31:1]);
      hi           = 32'(nn[44:32]);
      sat4_nxt[n]  = hi >= mu;
      r04_nxt[n]   = sat4_nxt[n] ? '0 : hi;
      low4_nxt[n]  = nn[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      dv_r <= '0;
    end else if (re) begin
      v1_r <= x_v_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      dv_r <= {dv_r[G_FRAC-2:0], v4_r};
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      t1_r.row  <= row_r;
      t1_r.last <= (row_r == LAST_ROW);
      t1_r.zero <= x_item_r.zero;
      cp1_r     <= x_item_r.cp;
      s1_r      <= s1_nxt;
      pm1_r     <= pm1_nxt;
      ps1_r     <= ps1_nxt;

      t2_r  <= t1_r;
      s2_r  <= s1_r;
      c2_r  <= c2_nxt;
      ps2_r <= ps1_r;

      t3_r  <= t2_r;
      vm3_r <= vm3_nxt;
      vn3_r <= vn3_nxt;
      for (int n = 0; n < NUM_ROWS; n++) begin
        pv3_r[n] <= 66'(vm3_nxt[n]) * 66'(SQRT2_Q30);
      end

      t4_r   <= t3_r;
      r04_r  <= r04_nxt;
      low4_r <= low4_nxt;
      sat4_r <= sat4_nxt;
      vn4_r  <= vn3_r;

      dt_r[0] <= dt_in;
      for (int s = 1; s < G_FRAC; s++) begin
        dt_r[s] <= dt_r[s-1];
      end
    end
  end

  assign dt_in.rt  = t4_r;
  assign dt_in.sat = sat4_r;
  assign dt_in.neg = vn4_r;

  for (genvar n = 0; n < NUM_ROWS; n++) begin : g_gdiv
    egm_div_pipe #(.W(32), .F(G_FRAC)) u_div (
      .clk (clk),
      .en  (re),
      .r0  (r04_r[n]),
      .d   (mu),
      .low (low4_r[n]),
      .q   (dq[n])
    );
  end

  always_comb begin
    for (int n = 0; n < NUM_ROWS; n++) begin
      if (dt_r[G_FRAC-1].rt.zero) begin
        g_nxt[n] = '0;
      end else if (dt_r[G_FRAC-1].sat[n]) begin
        g_nxt[n] = dt_r[G_FRAC-1].neg[n] ? NEG_SAT : POS_SAT;
      end else if (!dt_r[G_FRAC-1].neg[n]) begin
        g_nxt[n] = (dq[n] > POS_SAT) ? POS_SAT : dq[n];
      end else begin
        g_nxt[n] = (dq[n] > NEG_SAT) ? NEG_SAT : 32'(-dq[n]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (re) begin
      out_valid <= dv_r[G_FRAC-1];
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      out_row  <= dt_r[G_FRAC-1].rt.row;
      out_last <= dt_r[G_FRAC-1].rt.last;
      out_g    <= g_nxt;
    end
  end

endmodule

FILE: rtl/elastic_green_operator_mandel_top.sv
// Isotropic elastic Green operator in Mandel form: stream wrapper and config registers.
// Depends on egm_pkg, egm_front and egm_row.
//
// Use: one wave vector (kx, ky, kz) enters on the in_ stream and six row
// transactions leave on the out_ stream, rows 0..5, tlast on row 5.
// lame_lambda (index 0) and shear_mu (index 1) are written on the cfg_
// channel, which is always ready; write them only while the block is idle.
// Path: front product registers, front dividers, row sequencer, stages R1..R4, mu
// dividers, output register; then one row per cycle while out_tready is high. One
// vector per six rows, set by the single output channel; the front pipeline (31-stage
// dividers) can take a vector every cycle until it backs up behind the row sequencer.
// Reset clears every valid bit and loads the default Lame constants.
// When the receiver stalls, the whole row pipeline holds; the front
// pipeline keeps taking vectors until its last stage is occupied.
module elastic_green_operator_mandel_top import egm_pkg::*; #(
  parameter int K_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((3*K_WIDTH+7)/8)*8-1:0]      in_tdata,   // kx, ky, kz
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [OUT_DATA_W-1:0]               out_tdata,  // row, g0..g5
  output logic                                out_tlast,  // last_row
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [CFG_IDX_W-1:0]                cfg_index,
  input  logic [31:0]                         cfg_data
);

  logic [31:0] lambda_r;
  logic [31:0] mu_r;
  logic [31:0] mu_eff;
  logic        item_valid;
  logic        item_take;
  egm_item_t   item;
  logic [2:0]  out_row;
  logic [NUM_ROWS-1:0][31:0] out_g;

  assign cfg_ready = 1'b1;
  assign mu_eff    = (mu_r == '0) ? 32'd1 : mu_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lambda_r <= LAMBDA_RST;
      mu_r     <= MU_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LAMBDA: lambda_r <= cfg_data;
        REG_MU:     mu_r     <= cfg_data;
        default:    ;
      endcase
    end
  end

  egm_front #(.K_WIDTH(K_WIDTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .kx         (in_tdata[K_WIDTH-1:0]),
    .ky         (in_tdata[2*K_WIDTH-1:K_WIDTH]),
    .kz         (in_tdata[3*K_WIDTH-1:2*K_WIDTH]),
    .lambda     (lambda_r),
    .mu         (mu_eff),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  egm_row u_row (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .mu         (mu_eff),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_row    (out_row),
    .out_g      (out_g),
    .out_last   (out_tlast)
  );

  always_comb begin
    out_tdata      = '0;
    out_tdata[2:0] = out_row;
    for (int n = 0; n < NUM_ROWS; n++) begin
      out_tdata[3 + 32*n +: 32] = out_g[n];
    end
  end

endmodule

FILE: rtl/egm_checker.sv
// Port-level checks on the result stream of the Mandel Green operator block.
// Depends on egm_pkg; bound to elastic_green_operator_mandel_top.
module egm_checker import egm_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result transaction changed while stalled");

  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[2:0] == 3'd5)))
    else $error("tlast does not match row 5");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2:0] != 3'd6 && out_tdata[2:0] != 3'd7))
    else $error("row index out of range");

  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast ##1 out_tvalid
      |-> out_tdata[2:0] == $past(out_tdata[2:0]) + 3'd1)
    else $error("rows out of order");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind elastic_green_operator_mandel_top egm_checker u_egm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
